### hdl/wgm_pkg.sv
// shared constants, types and the star closure for the glob matcher
package wgm_pkg;

    localparam int PATTERN_MAX = 63;
    localparam int SET_W       = PATTERN_MAX + 1;
    localparam int POS_W       = $clog2(SET_W);

    localparam int KIND_W = 2;
    localparam int SLOT_W = 6;
    localparam int SYM_W  = 8;
    localparam int LEN_W  = 6;

    localparam logic [SYM_W-1:0] STAR_BYTE = 8'd42;
    localparam logic [SYM_W-1:0] ANY_BYTE  = 8'd63;

    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_PATTERN = 2'd0,
        KIND_STRING  = 2'd1,
        KIND_END     = 2'd2
    } kind_t;

    typedef struct packed {
        logic             step;
        logic             restart;
        logic [SYM_W-1:0] sym;
    } cell_ctrl_t;

    // star positions pass activity forward like a carry: generate where a
    // live position holds a star, propagate through every star position
    function automatic logic [SET_W-1:0] star_closure(
        input logic [SET_W-1:0] set,
        input logic [SET_W-1:0] star_mask,
        input logic [SET_W-1:0] end_mask
    );
        logic [SET_W-1:0] live;
        logic [SET_W-1:0] gen;
        logic [SET_W-1:0] carry_in;
        live     = set & end_mask;
        gen      = live & star_mask;
        carry_in = (star_mask + gen) ^ star_mask ^ gen;
        return live | carry_in;
    endfunction

endpackage

### hdl/wildcard_glob_matcher.sv
// Glob matcher ('*' any run, '?' any byte, no escape) over a streamed string.
// One item is taken per clock: pattern writes, string bytes and end-of-string
// items all go at full rate while the result queue has room. Each pattern
// position is a cell holding its byte and active bit; a string byte moves the
// active set across the row, with star runs resolved by a 64-bit carry chain.
// After a string's last byte (or its empty-string item) is taken, the advanced
// set is registered in the end-bit stage, then closed over trailing stars to
// pick the end bit, which is pushed into the result queue. in_stall rises only
// when the three-entry result queue plus the in-flight result would overflow,
// i.e. when out_stall has held results back.
module wildcard_glob_matcher (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [wgm_pkg::KIND_W-1:0]  kind,
    input  logic [wgm_pkg::SLOT_W-1:0]  slot,
    input  logic [wgm_pkg::SYM_W-1:0]   symbol,
    input  logic                        final_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        matched,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [wgm_pkg::LEN_W-1:0]   cfg_pattern_length
);
    import wgm_pkg::*;

    logic [LEN_W-1:0]      len_reg;
    logic [POS_W-1:0]      eff_len;
    logic [SET_W-1:0]      end_mask;
    logic [SET_W-1:0]      star_mask;
    logic [PATTERN_MAX-1:0] use_mask;
    logic [PATTERN_MAX-1:0] star_bits;

    logic [SET_W-1:0]      raw_set;
    logic [SET_W-1:0]      closed_set;
    logic [SET_W-1:0]      next_set;
    logic [SET_W-1:0]      fwd;

    logic                  end_reg;
    logic                  end_next;

    logic [SET_W-1:0]      fin_set_reg;
    logic [SET_W-1:0]      fin_set_next;
    logic                  fin_valid_reg;
    logic                  fin_valid_next;
    logic [SET_W-1:0]      fin_closed;

    logic                  accept;
    logic                  is_string;
    logic                  is_end;
    logic                  is_pattern;
    cell_ctrl_t            ctrl;

    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W:0]   fill;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            len_reg <= cfg_pattern_length;
        end
    end

    assign eff_len = (int'(len_reg) > PATTERN_MAX) ? POS_W'(PATTERN_MAX)
                   : POS_W'(len_reg);

    always_comb
    begin
        for (int i = 0; i < SET_W; i++)
        begin
            end_mask[i] = (POS_W'(i) <= eff_len);
        end
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            use_mask[i] = (POS_W'(i) < eff_len);
        end
    end

    assign star_mask = {1'b0, star_bits & use_mask};

    // input handshake
    assign fill     = (FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(fin_valid_reg);
    assign in_stall = (fill >= (FIFO_CNT_W + 1)'(FIFO_DEPTH));
    assign accept   = in_valid & ~in_stall;

    assign is_pattern = (kind_t'(kind) == KIND_PATTERN);
    assign is_string  = (kind_t'(kind) == KIND_STRING);
    assign is_end     = (kind_t'(kind) == KIND_END);

    assign ctrl.step    = accept & is_string & ~final_byte;
    assign ctrl.restart = accept & ((is_string & final_byte) | is_end);
    assign ctrl.sym     = symbol;

    // row of pattern cells
    assign closed_set = star_closure(raw_set, star_mask, end_mask);
    assign fwd[0]     = 1'b0;

    for (genvar g = 0; g < PATTERN_MAX; g++)
    begin : g_cell
        wgm_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .wr_en       (accept & is_pattern & (slot == SLOT_W'(g))),
            .wr_byte     (symbol),
            .restart_val (g == 0),
            .in_use      (use_mask[g]),
            .closed_in   (closed_set[g]),
            .fwd_in      (fwd[g]),
            .active      (raw_set[g]),
            .next_active (next_set[g]),
            .is_star     (star_bits[g]),
            .fwd_out     (fwd[g+1])
        );
    end

    // the last position has no pattern byte, only an active bit
    assign next_set[PATTERN_MAX] = fwd[PATTERN_MAX];
    assign raw_set[PATTERN_MAX]  = end_reg;

    always_comb
    begin
        end_next = end_reg;
        if (ctrl.restart)
        begin
            end_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            end_next = next_set[PATTERN_MAX];
        end
    end

    // end-bit stage: closure of the final set with the pattern as it stands
    always_comb
    begin
        fin_valid_next = ctrl.restart;
        fin_set_next   = is_string ? next_set : raw_set;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_reg       <= 1'b0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            end_reg       <= end_next;
            fin_valid_reg <= fin_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_valid_next)
        begin
            fin_set_reg <= fin_set_next;
        end
    end

    assign fin_closed = star_closure(fin_set_reg, star_mask, end_mask);

    wgm_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fin_valid_reg),
        .push_data (fin_closed[eff_len]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (matched),
        .count     (fifo_count)
    );

endmodule

### hdl/wgm_cell.sv
// one pattern position: stored pattern byte and its active bit
module wgm_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  wgm_pkg::cell_ctrl_t     ctrl,
    input  logic                    wr_en,
    input  logic [wgm_pkg::SYM_W-1:0] wr_byte,
    input  logic                    restart_val,
    input  logic                    in_use,
    input  logic                    closed_in,
    input  logic                    fwd_in,
    output logic                    active,
    output logic                    next_active,
    output logic                    is_star,
    output logic                    fwd_out
);
    import wgm_pkg::*;

    logic [SYM_W-1:0] pat_reg;
    logic             active_reg;
    logic             active_next;
    logic             live;
    logic             hit;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pat_reg <= wr_byte;
        end
    end

    assign is_star = (pat_reg == STAR_BYTE);
    assign live    = closed_in & in_use;
    assign hit     = (pat_reg == ctrl.sym) | (pat_reg == ANY_BYTE);

    // a star keeps its own position, anything else hands to the neighbor
    assign next_active = (live & is_star) | fwd_in;
    assign fwd_out     = live & ~is_star & hit;

    always_comb
    begin
        active_next = active_reg;
        if (ctrl.restart)
        begin
            active_next = restart_val;
        end
        else if (ctrl.step)
        begin
            active_next = next_active;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= restart_val;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    assign active = active_reg;

endmodule

### hdl/wgm_result_fifo.sv
// small result queue between the end-bit stage and the output port
module wgm_result_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          push_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          out_data,
    output logic [wgm_pkg::FIFO_CNT_W-1:0] count
);
    import wgm_pkg::*;

    logic                  mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid & ~out_stall;
    assign out_data  = mem[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
